// ----- hdl/pse_pkg.sv -----
// pse_pkg: shared constants for the printable string extractor
// register widths, reset values, register indexes, character bounds
// no dependencies
`default_nettype none

package pse_pkg;

    localparam int MIN_LEN_W      = 6;
    localparam int MAX_LEN_W      = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int HOLD_DEPTH_DEF = 32;
    localparam int RUN_LIMIT_DEF  = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 6'd6;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

    localparam logic [7:0] CHAR_LO   = 8'h20;
    localparam logic [7:0] CHAR_HI   = 8'h7E;
    localparam logic [7:0] CHAR_ZERO = 8'h00;

    // command word: store, emit, rel, mark, pos, last, chr
    function automatic int cmd_width(input int idx_w);
        return 4 + 2 * idx_w + 8;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pse_fifo.sv -----
// pse_fifo: small command queue between front and back parts
// depends on pse_pkg for the default depth
`default_nettype none

module pse_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = pse_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  full,
    output logic                  empty
);
    import pse_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("pse_fifo: push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pse_fifo: pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("pse_fifo: count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- hdl/pse_front.sv -----
// pse_front: accepts bytes, tracks the run and issues commands to the back part
// depends on pse_pkg
`default_nettype none

module pse_front #(
    parameter int HOLD_DEPTH = pse_pkg::HOLD_DEPTH_DEF,
    parameter int RUN_LIMIT  = pse_pkg::RUN_LIMIT_DEF,
    parameter int CMD_W      = pse_pkg::cmd_width($clog2(HOLD_DEPTH))
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // data_byte
    input  wire logic                          s_tuser,   // flush
    input  wire logic [pse_pkg::MIN_LEN_W-1:0] min_len,
    input  wire logic [pse_pkg::MAX_LEN_W-1:0] max_len,
    input  wire logic                          queue_full,
    output logic                               push,
    output logic [CMD_W-1:0]                   cmd
);
    import pse_pkg::*;

    localparam int IDX_W = $clog2(HOLD_DEPTH);
    localparam int CNT_W = $clog2(RUN_LIMIT + 1);
    localparam int CMP_W = (CNT_W > MAX_LEN_W) ? CNT_W : MAX_LEN_W;

    typedef struct packed {
        logic             store;
        logic             emit;
        logic             rel;
        logic             mark;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] last;
        logic [7:0]       chr;
    } cmd_t;

    logic [CNT_W-1:0] run_count_reg, run_count_next;
    logic             zero_skipped_reg, zero_skipped_next;

    logic [CNT_W-1:0] min_ext, mn, mx, rc_inc;
    logic [CMP_W-1:0] max_ext, mx_w;
    logic             accept, printable;
    cmd_t             c;

    assign s_tready  = !queue_full;
    assign accept    = s_tvalid && s_tready;
    assign printable = (s_tdata >= CHAR_LO) && (s_tdata <= CHAR_HI);
    assign rc_inc    = run_count_reg + 1'b1;

    always_comb
    begin
        min_ext = CNT_W'(min_len);
        if (min_ext == '0)
        begin
            mn = CNT_W'(1);
        end
        else if (min_ext > CNT_W'(HOLD_DEPTH))
        begin
            mn = CNT_W'(HOLD_DEPTH);
        end
        else
        begin
            mn = min_ext;
        end
        max_ext = CMP_W'(max_len);
        if (max_ext == '0)
        begin
            mx_w = CMP_W'(1);
        end
        else if (max_ext > CMP_W'(RUN_LIMIT))
        begin
            mx_w = CMP_W'(RUN_LIMIT);
        end
        else
        begin
            mx_w = max_ext;
        end
        mx = CNT_W'(mx_w);
    end

    always_comb
    begin
        run_count_next    = run_count_reg;
        zero_skipped_next = zero_skipped_reg;
        c                 = '0;
        c.chr             = s_tdata;
        c.pos             = run_count_reg[IDX_W-1:0];
        c.last            = IDX_W'(mn - CNT_W'(2));
        if (s_tuser)
        begin
            c.mark            = (run_count_reg >= mn);
            run_count_next    = '0;
            zero_skipped_next = 1'b0;
        end
        else if (printable)
        begin
            zero_skipped_next = 1'b0;
            c.store           = (run_count_reg < CNT_W'(HOLD_DEPTH));
            c.emit            = (rc_inc >= mn);
            c.rel             = (rc_inc == mn) && (mn > CNT_W'(1));
            if (rc_inc >= mx)
            begin
                c.mark         = (rc_inc >= mn);
                run_count_next = '0;
            end
            else
            begin
                run_count_next = rc_inc;
            end
        end
        else if ((s_tdata == CHAR_ZERO) && !zero_skipped_reg)
        begin
            zero_skipped_next = 1'b1;
        end
        else
        begin
            c.mark         = (run_count_reg >= mn);
            run_count_next = '0;
        end
    end

    assign push = accept && (c.store || c.emit || c.mark);
    assign cmd  = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg    <= '0;
            zero_skipped_reg <= 1'b0;
        end
        else if (accept)
        begin
            run_count_reg    <= run_count_next;
            zero_skipped_reg <= zero_skipped_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !queue_full)
        else $error("pse_front: command pushed while queue full");
`endif

endmodule

`default_nettype wire

// ----- hdl/pse_back.sv -----
// pse_back: executes commands, keeps held bytes and drives the output beat
// depends on pse_pkg
`default_nettype none

module pse_back #(
    parameter int HOLD_DEPTH = pse_pkg::HOLD_DEPTH_DEF,
    parameter int CMD_W      = pse_pkg::cmd_width($clog2(HOLD_DEPTH))
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire logic [CMD_W-1:0] cmd,
    output logic                  cmd_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // char_out
    output logic                  m_tlast    // end_marker
);
    import pse_pkg::*;

    localparam int IDX_W = $clog2(HOLD_DEPTH);

    typedef struct packed {
        logic             store;
        logic             emit;
        logic             rel;
        logic             mark;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] last;
        logic [7:0]       chr;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_REL  = 4'b0010,
        S_CHAR = 4'b0100,
        S_MARK = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [7:0]       chr_reg, chr_next;
    logic             mark_reg, mark_next;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [HOLD_DEPTH];

    cmd_t             c;
    logic             load_ok, load, ld_last, mem_we;
    logic [7:0]       ld_data;
    logic [IDX_W-1:0] rd_addr;

    assign c        = cmd;
    assign load_ok  = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        chr_next   = chr_reg;
        mark_next  = mark_reg;
        cmd_pop    = 1'b0;
        load       = 1'b0;
        ld_data    = CHAR_ZERO;
        ld_last    = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && load_ok)
                begin
                    cmd_pop = 1'b1;
                    mem_we  = c.store;
                    if (c.rel)
                    begin
                        idx_next   = '0;
                        last_next  = c.last;
                        chr_next   = c.chr;
                        mark_next  = c.mark;
                        rd_addr    = '0;
                        state_next = S_REL;
                    end
                    else if (c.emit)
                    begin
                        load    = 1'b1;
                        ld_data = c.chr;
                        if (c.mark)
                        begin
                            state_next = S_MARK;
                        end
                    end
                    else if (c.mark)
                    begin
                        load    = 1'b1;
                        ld_last = 1'b1;
                    end
                end
            end
            S_REL:
            begin
                if (load_ok)
                begin
                    load    = 1'b1;
                    ld_data = rd_data_reg;
                    if (idx_reg == last_reg)
                    begin
                        state_next = S_CHAR;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            S_CHAR:
            begin
                if (load_ok)
                begin
                    load       = 1'b1;
                    ld_data    = chr_reg;
                    state_next = mark_reg ? S_MARK : S_IDLE;
                end
            end
            S_MARK:
            begin
                if (load_ok)
                begin
                    load       = 1'b1;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            last_reg      <= '0;
            mark_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            mark_reg  <= mark_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg <= chr_next;
        if (load)
        begin
            out_data_reg <= ld_data;
            out_last_reg <= ld_last;
        end
    end

    // held byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[c.pos] <= c.chr;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata == CHAR_ZERO))
        else $error("pse_back: end marker beat carries a character");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REL && load_ok && idx_reg == last_reg) |=> (state_reg == S_CHAR))
        else $error("pse_back: release did not finish with the current byte");
`endif

endmodule

`default_nettype wire

// ----- hdl/printable_string_extractor.sv -----
// path: a passed byte or end marker goes through the command queue and the output register,
// the first byte of a release also through the registered read of the held byte store
// throughput: one input beat per cycle while the command queue is not full; a release of held
// bytes keeps the back part busy in its release and current-byte states and an end marker after
// a byte in its marker state, the 4-entry command queue absorbing this before the input stalls
// reset: asynchronous, clears run state, queue and output; min_len 6, max_len 4096;
// the held byte store is not cleared
`default_nettype none

module printable_string_extractor #(
    parameter int HOLD_DEPTH = pse_pkg::HOLD_DEPTH_DEF,
    parameter int RUN_LIMIT  = pse_pkg::RUN_LIMIT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // data_byte
    input  wire logic                          s_tuser,   // flush
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // char_out
    output logic                               m_tlast,   // end_marker
    input  wire logic                          cfg_we,
    input  wire logic [pse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pse_pkg::MAX_LEN_W-1:0] cfg_data
);
    import pse_pkg::*;

    localparam int CMD_W = cmd_width($clog2(HOLD_DEPTH));

    logic [MIN_LEN_W-1:0] min_len_reg;
    logic [MAX_LEN_W-1:0] max_len_reg;
    logic                 queue_full, queue_empty, push, pop;
    logic [CMD_W-1:0]     push_cmd, pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RST;
            max_len_reg <= MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_LEN: min_len_reg <= cfg_data[MIN_LEN_W-1:0];
                REG_MAX_LEN: max_len_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    pse_front #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .RUN_LIMIT  (RUN_LIMIT),
        .CMD_W      (CMD_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .min_len    (min_len_reg),
        .max_len    (max_len_reg),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    pse_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    pse_back #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!queue_empty),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
